// ===== src/sfce_pkg.sv =====
package sfce_pkg;

    localparam logic [15:0] CRC_POLY  = 16'h39B7;
    localparam logic [15:0] TAB1_BASE = 16'h39B7;
    localparam logic [15:0] TAB2_BASE = 16'h7648;

    typedef struct packed {
        logic        first_word;
        logic        last_word;
        logic        send_mode;
        logic [7:0]  command_byte;
        logic [15:0] connection_id;
        logic [15:0] sequence_in;
        logic [15:0] start_crc;
        logic [15:0] previous_crc;
        logic [15:0] data_word;
        logic        single_byte_data;
        logic [15:0] received_crc;
    } in_item_t;

    typedef struct packed {
        logic [15:0] crc_value;
        logic [15:0] sequence_out;
        logic        crc_ok;
        logic        frame_done;
    } out_item_t;

    // Byte source for one CRC step
    typedef enum logic [2:0] {
        SRC_SCRC_LO, SRC_SCRC_HI, SRC_CONN_LO, SRC_CONN_HI,
        SRC_SEQ_LO, SRC_SEQ_HI, SRC_CMD, SRC_IDX_LO
    } byte_src_t;

    typedef struct packed {
        logic      load_item;    // capture input item
        logic      clear_crc;    // crc <= 0
        logic      seed_common;  // crc <= common header crc
        logic      step;         // advance crc by one byte
        byte_src_t src;
        logic      use_data;     // byte comes from data word
        logic      data_hi;
        logic      idx_hi;       // with SRC_IDX_LO selects index high byte
        logic      save_common;  // common <= crc
        logic      step_seq;     // sequence <= next sequence
        logic      finish_first; // latch first-word results
        logic      finish_later; // latch later-word results
        logic      set_fail;
    } dp_cmd_t;

    typedef struct packed {
        logic first_word;
        logic single;
        logic mode_send;   // send mode of the captured first word
        logic frame_send;  // latched frame mode
        logic crc_eq_prev;
        logic crc_eq_rcv;
    } dp_status_t;

    function automatic logic [15:0] gf_mul(input logic [15:0] base, input logic [7:0] v);
        logic [15:0] r;
        r = '0;
        for (int b = 7; b >= 0; b--) begin
            r = {r[14:0], 1'b0} ^ (r[15] ? CRC_POLY : 16'h0000) ^ (v[b] ? base : 16'h0000);
        end
        return r;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] w;
        w = gf_mul(TAB1_BASE, crc[15:8]) ^ gf_mul(TAB2_BASE, d);
        return {w[15:8] ^ crc[7:0], w[7:0]};
    endfunction

    function automatic logic [15:0] next_seq(input logic [15:0] s);
        logic [15:0] t;
        t = s + 16'd1;
        return (t == 16'd0) ? 16'd1 : t;
    endfunction

endpackage

// ===== src/sfce_datapath.sv =====
module sfce_datapath
    import sfce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   in_item,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output out_item_t  result
);

    in_item_t    item_reg;
    logic [15:0] crc_reg;
    logic [15:0] common_reg;
    logic [15:0] seq_reg;
    logic [15:0] index_reg;
    logic        fail_reg;
    logic        send_reg;
    logic [15:0] frame_seq_reg;
    logic [15:0] res_crc_reg;
    logic [7:0]  byte_sel;
    logic [15:0] crc_next;

    // Select the byte for this step
    always_comb
    begin
        if (cmd.use_data)
            byte_sel = cmd.data_hi ? item_reg.data_word[15:8] : item_reg.data_word[7:0];
        else
        begin
            case (cmd.src)
                SRC_SCRC_LO: byte_sel = item_reg.start_crc[7:0];
                SRC_SCRC_HI: byte_sel = item_reg.start_crc[15:8];
                SRC_CONN_LO: byte_sel = item_reg.connection_id[7:0];
                SRC_CONN_HI: byte_sel = item_reg.connection_id[15:8];
                SRC_SEQ_LO:  byte_sel = seq_reg[7:0];
                SRC_SEQ_HI:  byte_sel = seq_reg[15:8];
                SRC_CMD:     byte_sel = item_reg.command_byte;
                SRC_IDX_LO:  byte_sel = cmd.idx_hi ? index_reg[15:8] : index_reg[7:0];
                default:     byte_sel = 8'h00;
            endcase
        end
    end

    always_comb
    begin
        crc_next = crc_reg;
        if (cmd.clear_crc)
            crc_next = 16'h0000;
        else if (cmd.seed_common)
            crc_next = common_reg;
        else if (cmd.step)
            crc_next = crc_byte(crc_reg, byte_sel);
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            item_reg <= in_item;
        crc_reg <= crc_next;
    end

    // Frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            common_reg    <= 16'h0000;
            seq_reg       <= 16'h0001;
            index_reg     <= 16'h0000;
            fail_reg      <= 1'b0;
            send_reg      <= 1'b0;
            frame_seq_reg <= 16'h0001;
            res_crc_reg   <= 16'h0000;
        end
        else
        begin
            if (cmd.load_item && in_item.first_word)
                seq_reg <= in_item.sequence_in;
            else if (cmd.step_seq)
                seq_reg <= next_seq(seq_reg);
            if (cmd.save_common)
                common_reg <= crc_reg;
            if (cmd.finish_first)
            begin
                send_reg      <= item_reg.send_mode;
                fail_reg      <= cmd.set_fail;
                frame_seq_reg <= seq_reg;
                index_reg     <= 16'd1;
                res_crc_reg   <= crc_reg;
            end
            else if (cmd.finish_later)
            begin
                if (cmd.set_fail)
                    fail_reg <= 1'b1;
                index_reg   <= index_reg + 16'd1;
                res_crc_reg <= crc_reg;
            end
        end
    end

    assign status.first_word  = item_reg.first_word;
    assign status.single      = item_reg.single_byte_data;
    assign status.mode_send   = item_reg.send_mode;
    assign status.frame_send  = send_reg;
    assign status.crc_eq_prev = (crc_reg == item_reg.previous_crc);
    assign status.crc_eq_rcv  = (crc_reg == item_reg.received_crc);

    assign result.crc_value    = res_crc_reg;
    assign result.sequence_out = frame_seq_reg;
    assign result.crc_ok       = send_reg | ~fail_reg;
    assign result.frame_done   = item_reg.last_word;

endmodule

// ===== src/sfce_control.sv =====
module sfce_control
    import sfce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_HDR   = 5'b00010,
        ST_DATA  = 5'b00100,
        ST_DECIDE = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;   // byte step within a phase
    logic [1:0] tries_reg, tries_next;

    // Header byte order: start crc, connection id, sequence, command
    function automatic byte_src_t hdr_src(input logic [2:0] n);
        byte_src_t s;
        case (n)
            3'd0:    s = SRC_SCRC_LO;
            3'd1:    s = SRC_SCRC_HI;
            3'd2:    s = SRC_CONN_LO;
            3'd3:    s = SRC_CONN_HI;
            3'd4:    s = SRC_SEQ_LO;
            3'd5:    s = SRC_SEQ_HI;
            default: s = SRC_CMD;
        endcase
        return s;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        tries_next = tries_reg;
        cmd        = '0;
        cmd.src    = SRC_CMD;
        in_ready   = (state_reg == ST_IDLE) || (state_reg == ST_OUT && out_ready);
        out_valid  = (state_reg == ST_OUT);
        case (state_reg)
            ST_IDLE, ST_OUT:
            begin
                if (out_valid && out_ready)
                    state_next = ST_IDLE;
                if (in_valid && in_ready)
                begin
                    cmd.load_item = 1'b1;
                    cnt_next      = 3'd0;
                    tries_next    = 2'd0;
                    state_next    = ST_HDR;
                end
            end
            ST_HDR:
            begin
                // first word: clear then seven header bytes; later: seed, two index bytes
                if (status.first_word)
                begin
                    if (cnt_reg == 3'd0)
                    begin
                        cmd.clear_crc = 1'b1;
                        cnt_next      = 3'd1;
                    end
                    else
                    begin
                        cmd.step = 1'b1;
                        cmd.src  = hdr_src(cnt_reg - 3'd1);
                        cnt_next = cnt_reg + 3'd1;
                        if (cnt_reg == 3'd7)
                        begin
                            cnt_next   = 3'd0;
                            state_next = ST_DATA;
                        end
                    end
                end
                else
                begin
                    if (cnt_reg == 3'd0)
                    begin
                        cmd.seed_common = 1'b1;
                        cnt_next        = 3'd1;
                    end
                    else
                    begin
                        cmd.step   = 1'b1;
                        cmd.src    = SRC_IDX_LO;
                        cmd.idx_hi = (cnt_reg == 3'd2);
                        cnt_next   = cnt_reg + 3'd1;
                        if (cnt_reg == 3'd2)
                        begin
                            cnt_next   = 3'd0;
                            state_next = ST_DATA;
                        end
                    end
                end
            end
            ST_DATA:
            begin
                if (cnt_reg == 3'd0 && status.first_word)
                    cmd.save_common = 1'b1;
                cmd.step     = 1'b1;
                cmd.use_data = 1'b1;
                cmd.data_hi  = cnt_reg[0];
                cnt_next     = cnt_reg + 3'd1;
                if (cnt_reg[0] || (status.first_word && status.single))
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cnt_next = 3'd0;
                if (!status.first_word)
                begin
                    cmd.finish_later = 1'b1;
                    cmd.set_fail     = !status.frame_send && !status.crc_eq_rcv;
                    state_next       = ST_OUT;
                end
                else if (status.mode_send)
                begin
                    if (!status.crc_eq_prev || tries_reg == 2'd2)
                    begin
                        cmd.finish_first = 1'b1;
                        state_next       = ST_OUT;
                    end
                    else
                    begin
                        cmd.step_seq = 1'b1;
                        tries_next   = tries_reg + 2'd1;
                        state_next   = ST_HDR;
                    end
                end
                else
                begin
                    if (status.crc_eq_rcv || tries_reg == 2'd2)
                    begin
                        cmd.finish_first = 1'b1;
                        cmd.set_fail     = !status.crc_eq_rcv;
                        state_next       = ST_OUT;
                    end
                    else
                    begin
                        cmd.step_seq = 1'b1;
                        tries_next   = tries_reg + 2'd1;
                        state_next   = ST_HDR;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 3'd0;
            tries_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            tries_reg <= tries_next;
        end
    end

`ifndef ASSERT_OFF
    // No more than three header passes per first word
    a_tries: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DECIDE |-> tries_reg != 2'd3)
        else $error("retry count overran");
    // A result is produced only from the decide step
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == ST_DECIDE)
        else $error("result without decision");
    // Input is never taken in the middle of a computation
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HDR || state_reg == ST_DATA || state_reg == ST_DECIDE) |-> !in_ready)
        else $error("input accepted while busy");
`endif

endmodule

// ===== src/safety_frame_crc_engine_top.sv =====
// Channel | Handshake             | Payload
// in      | in_valid / in_ready   | in_item  (in_item_t)
// out     | out_valid / out_ready | out_item (out_item_t)
//
// One byte of CRC per cycle through the shared table step.
// Later word: seed, 2 index bytes, 2 data bytes, decide, out.
// First word: each header pass is clear, 7 header bytes, 1 or 2 data bytes and decide;
// up to three passes, then the output state.
// Asynchronous active-low reset clears frame state and the controller.
// A new item is accepted in the cycle its predecessor's result transfers.
module safety_frame_crc_engine_top
    import sfce_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    dp_cmd_t    cmd;
    dp_status_t status;

    sfce_control u_control (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    sfce_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_item),
        .cmd     (cmd),
        .status  (status),
        .result  (out_item)
    );

endmodule

// ===== dv/safety_frame_crc_engine_top_test.sv =====
`timescale 1ns / 100ps

module safety_frame_crc_engine_top_test;
    import sfce_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    // frame state of the CRC predictor
    logic [15:0] mdl_header_crc;
    logic [15:0] mdl_sequence;
    logic [15:0] mdl_word_index;
    logic        mdl_check_failed;
    logic        mdl_send_mode;

    out_item_t   expected_crcs[$];
    int          error_count;
    bit          hold_off_request;

    // frame history: start crc, connection, sequence, command
    logic [15:0] frame_start_crc;
    logic [15:0] frame_conn;
    logic [15:0] frame_seq;
    logic [7:0]  frame_cmd;

    safety_frame_crc_engine_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // one polynomial multiply over GF(2), MSB first
    function automatic logic [15:0] poly_mult(logic [15:0] base, logic [7:0] v);
        logic [15:0] r;
        r = 16'h0000;
        for (int b = 7; b >= 0; b--)
        begin
            r = {r[14:0], 1'b0} ^ (r[15] ? 16'h39B7 : 16'h0000) ^ (v[b] ? base : 16'h0000);
        end
        return r;
    endfunction

    function automatic logic [15:0] advance_byte(logic [15:0] crc, logic [7:0] d);
        logic [15:0] w;
        w = poly_mult(16'h39B7, crc[15:8]) ^ poly_mult(16'h7648, d);
        return {w[15:8] ^ crc[7:0], w[7:0]};
    endfunction

    function automatic logic [15:0] advance_word(logic [15:0] crc, logic [15:0] v);
        return advance_byte(advance_byte(crc, v[7:0]), v[15:8]);
    endfunction

    function automatic logic [15:0] step_sequence(logic [15:0] s);
        logic [15:0] t;
        t = s + 16'd1;
        return (t == 16'h0000) ? 16'h0001 : t;
    endfunction

    function automatic logic [15:0] header_crc(in_item_t it, logic [15:0] seq);
        logic [15:0] c;
        c = advance_word(16'h0000, it.start_crc);
        c = advance_word(c, it.connection_id);
        c = advance_word(c, seq);
        return advance_byte(c, it.command_byte);
    endfunction

    function automatic logic [15:0] word0_crc(in_item_t it, logic [15:0] seq);
        logic [15:0] c;
        c = header_crc(it, seq);
        return it.single_byte_data ? advance_byte(c, it.data_word[7:0])
                                   : advance_word(c, it.data_word);
    endfunction

    // predict the result of one accepted word
    function automatic out_item_t predict_word_crc(in_item_t it);
        out_item_t   res;
        logic [15:0] seq;
        logic [15:0] c;
        int          tries;
        if (it.first_word)
        begin
            seq = it.sequence_in;
            tries = 0;
            mdl_send_mode = it.send_mode;
            mdl_check_failed = 1'b0;
            forever
            begin
                mdl_header_crc = header_crc(it, seq);
                c = word0_crc(it, seq);
                if (mdl_send_mode)
                begin
                    if (c != it.previous_crc || tries >= 2) break;
                end
                else
                begin
                    if (c == it.received_crc) break;
                    if (tries >= 2)
                    begin
                        mdl_check_failed = 1'b1;
                        break;
                    end
                end
                tries++;
                seq = step_sequence(seq);
            end
            mdl_sequence = seq;
            mdl_word_index = 16'd1;
        end
        else
        begin
            c = advance_word(advance_word(mdl_header_crc, mdl_word_index), it.data_word);
            if (!mdl_send_mode && c != it.received_crc) mdl_check_failed = 1'b1;
            mdl_word_index = mdl_word_index + 16'd1;
        end
        res.crc_value = c;
        res.sequence_out = mdl_sequence;
        res.crc_ok = mdl_send_mode || !mdl_check_failed;
        res.frame_done = it.last_word;
        return res;
    endfunction

    // drive one item and wait for its transfer
    task automatic send_word(in_item_t it);
        in_item = it;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        expected_crcs.push_back(predict_word_crc(it));
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // random idle between items, mostly short
    task automatic sender_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        repeat (n) @(negedge clk);
    endtask

    function automatic in_item_t random_item();
        in_item_t     it;
        logic [127:0] r;
        r = {$urandom, $urandom, $urandom, $urandom};
        it = r[$bits(in_item_t)-1:0];
        return it;
    endfunction

    // mostly well-formed frames; some words carry the correct CRC
    task automatic send_frame(int words, bit send, bit good);
        in_item_t    it;
        logic [15:0] c;
        for (int w = 0; w < words; w++)
        begin
            it = random_item();
            it.first_word = (w == 0);
            it.last_word = (w == words - 1);
            it.send_mode = send;
            if (w == 0)
            begin
                if (it.sequence_in == 16'h0000) it.sequence_in = 16'h0001;
                if ($urandom_range(0, 2) == 0)
                    it.sequence_in = 16'hFFFF - 16'($urandom_range(0, 1));
                c = word0_crc(it, it.sequence_in);
                case ($urandom_range(0, 3))
                    0: it.previous_crc = c;
                    default: ;
                endcase
                if (good)
                begin
                    case ($urandom_range(0, 2))
                        0: it.received_crc = c;
                        1: it.received_crc = word0_crc(it, step_sequence(it.sequence_in));
                        default: it.received_crc = word0_crc(it,
                                     step_sequence(step_sequence(it.sequence_in)));
                    endcase
                end
            end
            else if (good || $urandom_range(0, 1))
            begin
                // build the correct CRC from the predictor state before it advances
                it.received_crc = advance_word(advance_word(mdl_header_crc, mdl_word_index),
                                               it.data_word);
            end
            send_word(it);
            sender_gap();
        end
    endtask

    task automatic wait_drained();
        while (expected_crcs.size() != 0) @(negedge clk);
    endtask

    task automatic test_directed();
        in_item_t it;
        // later word before any frame
        it = '0;
        it.last_word = 1'b1;
        it.data_word = 16'hFFFF;
        send_word(it);
        // extremes of header fields, both modes, single byte
        for (int k = 0; k < 4; k++)
        begin
            it = '0;
            it.first_word = 1'b1;
            it.send_mode = k[0];
            it.single_byte_data = k[1];
            it.sequence_in = (k == 0) ? 16'h0000 : 16'hFFFF;
            if (k == 3)
            begin
                it.command_byte = 8'hFF;
                it.connection_id = 16'hFFFF;
                it.start_crc = 16'hFFFF;
                it.data_word = 16'hFFFF;
                it.received_crc = 16'hFFFF;
            end
            it.previous_crc = word0_crc(it, it.sequence_in);
            send_word(it);
        end
        send_frame(3, 1'b1, 1'b1);
        send_frame(3, 1'b0, 1'b1);
        send_frame(3, 1'b0, 1'b0);
        send_frame(1, 1'b0, 1'b1);
        wait_drained();
    endtask

    // run of later words with random received CRCs after a one-word frame
    task automatic test_later_words();
        in_item_t it;
        send_frame(1, 1'b1, 1'b1);
        for (int w = 0; w < 6; w++)
        begin
            it = random_item();
            it.first_word = 1'b0;
            send_word(it);
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_off_request = 1'b1;
        send_frame(8, 1'b0, 1'b1);
        wait_drained();
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 900)
        begin
            int n;
            n = $urandom_range(1, 6);
            if ($urandom_range(0, 9) == 0)
            begin
                send_word(random_item());
                sender_gap();
                n = 1;
            end
            else
                send_frame(n, 1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);
            sent += n;
        end
        wait_drained();
    endtask

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_request)
            begin
                out_ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_off_request = 1'b0;
            end
            case ($urandom_range(0, 19))
                0: out_ready <= 1'b0;
                1: begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(5, 40)) @(negedge clk);
                end
                2, 3, 4: out_ready <= ($urandom_range(0, 1) == 1);
                default: out_ready <= 1'b1;
            endcase
        end
    end

    // check each transfer against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_crcs.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, out_item);
                error_count++;
            end
            else
            begin
                out_item_t e;
                e = expected_crcs.pop_front();
                if (out_item.crc_value !== e.crc_value)
                begin
                    $display("%0t: crc_value expected %h actual %h", $time,
                             e.crc_value, out_item.crc_value);
                    error_count++;
                end
                if (out_item.sequence_out !== e.sequence_out)
                begin
                    $display("%0t: sequence_out expected %h actual %h", $time,
                             e.sequence_out, out_item.sequence_out);
                    error_count++;
                end
                if (out_item.crc_ok !== e.crc_ok)
                begin
                    $display("%0t: crc_ok expected %b actual %b", $time,
                             e.crc_ok, out_item.crc_ok);
                    error_count++;
                end
                if (out_item.frame_done !== e.frame_done)
                begin
                    $display("%0t: frame_done expected %b actual %b", $time,
                             e.frame_done, out_item.frame_done);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        error_count = 0;
        hold_off_request = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        mdl_header_crc = 16'h0000;
        mdl_sequence = 16'h0001;
        mdl_word_index = 16'h0000;
        mdl_check_failed = 1'b0;
        mdl_send_mode = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_backpressure();
        test_later_words();
        test_random();
        repeat (100) @(negedge clk);
        if (error_count == 0 && expected_crcs.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
src/sfce_pkg.sv
src/sfce_datapath.sv
src/sfce_control.sv
src/safety_frame_crc_engine_top.sv
dv/safety_frame_crc_engine_top_test.sv
